FILE: rtl/core/rrtq_pkg.sv
package rrtq_pkg;

  // Command codes carried in the kind field of a command word.
  localparam logic [2:0] KIND_ADD_WAIT = 3'd0;
  localparam logic [2:0] KIND_ADD_RUN  = 3'd1;
  localparam logic [2:0] KIND_REM_WAIT = 3'd2;
  localparam logic [2:0] KIND_REM_RUN  = 3'd3;
  localparam logic [2:0] KIND_DESTROY  = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;

  // Fault codes reported in a result word.
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_NOTFOUND = 2'd1;
  localparam logic [1:0] FAULT_FULL     = 2'd2;

  // Operations one list engine performs.
  typedef enum logic [1:0] {
    LOP_PUSH,
    LOP_REMOVE,
    LOP_POP
  } lst_op_e;

  typedef enum logic {
    LS_IDLE,
    LS_WALK
  } lst_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A,
    ST_B,
    ST_C,
    ST_D,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic    start;
    lst_op_e op;
  } lst_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } lst_rsp_t;

endpackage

FILE: rtl/core/rrtq_cmd_if.sv
interface rrtq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] thread_id;
  logic        must_exist;

  modport source (output valid, output kind, output thread_id, output must_exist,
                  input ready);
  modport sink (input valid, input kind, input thread_id, input must_exist,
                output ready);
endinterface

FILE: rtl/core/rrtq_rsp_if.sv
interface rrtq_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] chosen_id;
  logic [1:0]  fault;
  logic [6:0]  waiting_count;
  logic [6:0]  running_count;

  modport source (output valid, output chosen_id, output fault,
                  output waiting_count, output running_count, input ready);
  modport sink (input valid, input chosen_id, input fault,
                input waiting_count, input running_count, output ready);
endinterface

FILE: rtl/core/rrtq_list.sv
module rrtq_list
  import rrtq_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned W     = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lst_req_t       req_i,
  input  logic [W-1:0]   id_i,
  output lst_rsp_t       rsp_o,
  output logic [W-1:0]   head_o,
  output logic [LW-1:0]  len_o
);

  logic [W-1:0] mem [DEPTH];

  lst_state_e    state_q, state_d;
  lst_op_e       op_q, op_d;
  logic [W-1:0]  id_q, id_d;
  logic [LW-1:0] n_q, n_d;
  logic [LW-1:0] ridx_q, ridx_d;
  logic [AW-1:0] didx_q, didx_d;
  logic          rvalid_q, rvalid_d;
  logic          found_q, found_d;
  logic [W-1:0]  head_q, head_d;
  logic [LW-1:0] len_q, len_d;
  logic          done_q, done_d;
  logic          hit_q, hit_d;
  logic [W-1:0]  rdata_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic          re;
  logic [AW-1:0] raddr;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    id_d     = id_q;
    n_d      = n_q;
    ridx_d   = ridx_q;
    didx_d   = didx_q;
    rvalid_d = 1'b0;
    found_d  = found_q;
    head_d   = head_q;
    len_d    = len_q;
    done_d   = 1'b0;
    hit_d    = hit_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = ridx_q[AW-1:0];
    unique case (state_q)
      LS_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op;
          id_d = id_i;
          unique case (req_i.op)
            LOP_PUSH: begin
              done_d = 1'b1;
              if (len_q < LW'(DEPTH)) begin
                we    = 1'b1;
                waddr = len_q[AW-1:0];
                wdata = id_i;
                len_d = len_q + LW'(1);
                hit_d = 1'b1;
              end else begin
                hit_d = 1'b0;
              end
            end
            LOP_REMOVE, LOP_POP: begin
              n_d     = len_q;
              ridx_d  = '0;
              found_d = 1'b0;
              state_d = LS_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      LS_WALK: begin
        // Reads stream ahead one entry; once the match is seen, every later
        // entry is written back one place lower, which closes the gap.
        re       = ridx_q < n_q;
        rvalid_d = re;
        if (re) begin
          ridx_d = ridx_q + LW'(1);
          didx_d = ridx_q[AW-1:0];
        end
        if (rvalid_q) begin
          if (found_q) begin
            we    = 1'b1;
            waddr = didx_q - AW'(1);
            wdata = rdata_q;
          end else if (op_q == LOP_POP || rdata_q == id_q) begin
            found_d = 1'b1;
            head_d  = rdata_q;
          end
        end
        if (!re && !rvalid_q) begin
          state_d = LS_IDLE;
          done_d  = 1'b1;
          hit_d   = found_q;
          if (found_q) begin
            len_d = n_q - LW'(1);
          end
        end
      end
      default: begin
        state_d = LS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LS_IDLE;
      len_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
      op_q     <= LOP_PUSH;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      done_q   <= done_d;
      hit_q    <= hit_d;
      rvalid_q <= rvalid_d;
      found_q  <= found_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    n_q    <= n_d;
    ridx_q <= ridx_d;
    didx_q <= didx_d;
    head_q <= head_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;
  assign head_o     = head_q;
  assign len_o      = len_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(DEPTH))
    else $error("list length above depth");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == LS_IDLE)
    else $error("list operation started while busy");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> waddr != raddr)
    else $error("compaction write hit the entry being read");

  a_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q && op_q != LOP_PUSH) |-> len_q == n_q - LW'(1))
    else $error("removal did not shorten the list by one");

endmodule

FILE: rtl/core/round_robin_thread_queue.sv
// Channel  Dir  Interface    Word
// cmd_i    in   rrtq_cmd_if  kind, thread_id, must_exist
// rsp_o    out  rrtq_rsp_if  chosen_id, fault, waiting_count, running_count
//
// An append's result word is registered once the entry is written, a removal's once the
// one-entry-per-cycle walk through the list memory has passed every entry. A destroy
// walks the running list and then the waiting list; a tick walks the running list,
// appends to and pops the waiting list and then appends to the running list.
// Reset clears both counts at once; the list memories need no clearing pass.
// A new command is accepted while the previous result still waits in rsp_o.
module round_robin_thread_queue
  import rrtq_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 64,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrtq_cmd_if.sink   cmd_i,
  rrtq_rsp_if.source rsp_o
);

  localparam int unsigned LW = $clog2(LIST_DEPTH + 1);

  seq_state_e         state_q, state_d;
  logic [2:0]         kind_q, kind_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic               must_q, must_d;
  logic [1:0]         fault_q, fault_d;
  logic [ID_BITS-1:0] next_q, next_d;

  logic        ovalid_q, ovalid_d;
  logic [15:0] onext_q, onext_d;
  logic [1:0]  ofault_q, ofault_d;
  logic [6:0]  owc_q, owc_d;
  logic [6:0]  orc_q, orc_d;

  lst_req_t           w_req, r_req;
  lst_rsp_t           w_rsp, r_rsp;
  logic [ID_BITS-1:0] w_id, r_id;
  logic [ID_BITS-1:0] w_head, r_head;
  logic [LW-1:0]      w_len, r_len;

  logic [ID_BITS+15:0] id_ext;
  logic [ID_BITS-1:0]  id_in;
  logic [ID_BITS+15:0] next_ext;
  logic [LW+6:0]       wc_ext, rc_ext;
  logic                lst_done, lst_hit;

  assign id_ext   = {{ID_BITS{1'b0}}, cmd_i.thread_id};
  assign id_in    = id_ext[ID_BITS-1:0];
  assign next_ext = {16'b0, next_q};
  assign wc_ext   = {7'b0, w_len};
  assign rc_ext   = {7'b0, r_len};
  assign lst_done = w_rsp.done | r_rsp.done;
  assign lst_hit  = w_rsp.done ? w_rsp.hit : r_rsp.hit;

  function automatic logic [1:0] note_fault(logic [1:0] cur, logic [1:0] code);
    return (cur == FAULT_NONE) ? code : cur;
  endfunction

  rrtq_list #(.DEPTH(LIST_DEPTH), .W(ID_BITS)) u_waiting (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (w_req),
    .id_i   (w_id),
    .rsp_o  (w_rsp),
    .head_o (w_head),
    .len_o  (w_len)
  );

  rrtq_list #(.DEPTH(LIST_DEPTH), .W(ID_BITS)) u_running (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (r_req),
    .id_i   (r_id),
    .rsp_o  (r_rsp),
    .head_o (r_head),
    .len_o  (r_len)
  );

  assign cmd_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    id_d     = id_q;
    must_d   = must_q;
    fault_d  = fault_q;
    next_d   = next_q;
    ovalid_d = ovalid_q && !rsp_o.ready;
    onext_d  = onext_q;
    ofault_d = ofault_q;
    owc_d    = owc_q;
    orc_d    = orc_q;
    w_req    = '{start: 1'b0, op: LOP_PUSH};
    r_req    = '{start: 1'b0, op: LOP_PUSH};
    w_id     = id_q;
    r_id     = id_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d  = cmd_i.kind;
          id_d    = id_in;
          must_d  = cmd_i.must_exist;
          fault_d = FAULT_NONE;
          next_d  = id_in;
          w_id    = id_in;
          r_id    = id_in;
          state_d = ST_A;
          unique case (cmd_i.kind)
            KIND_ADD_WAIT: w_req = '{start: 1'b1, op: LOP_PUSH};
            KIND_ADD_RUN:  r_req = '{start: 1'b1, op: LOP_PUSH};
            KIND_REM_WAIT: w_req = '{start: 1'b1, op: LOP_REMOVE};
            KIND_REM_RUN, KIND_DESTROY: r_req = '{start: 1'b1, op: LOP_REMOVE};
            KIND_TICK: begin
              if (w_len != '0) begin
                r_req = '{start: 1'b1, op: LOP_REMOVE};
              end else begin
                state_d = ST_OUT;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_A: begin
        if (lst_done) begin
          state_d = ST_OUT;
          unique case (kind_q)
            KIND_ADD_WAIT, KIND_ADD_RUN: begin
              if (!lst_hit) fault_d = note_fault(fault_q, FAULT_FULL);
            end
            KIND_REM_WAIT, KIND_REM_RUN: begin
              if (!lst_hit && must_q) fault_d = note_fault(fault_q, FAULT_NOTFOUND);
            end
            KIND_DESTROY: begin
              w_req   = '{start: 1'b1, op: LOP_REMOVE};
              state_d = ST_D;
            end
            KIND_TICK: begin
              // The current thread must have been running; the tick goes on anyway.
              if (!lst_hit) fault_d = note_fault(fault_q, FAULT_NOTFOUND);
              w_req   = '{start: 1'b1, op: LOP_PUSH};
              state_d = ST_B;
            end
            default: begin
            end
          endcase
        end
      end
      ST_B: begin
        if (lst_done) begin
          if (!lst_hit) fault_d = note_fault(fault_q, FAULT_FULL);
          w_req   = '{start: 1'b1, op: LOP_POP};
          state_d = ST_C;
        end
      end
      ST_C: begin
        if (lst_done) begin
          r_id    = w_head;
          r_req   = '{start: 1'b1, op: LOP_PUSH};
          next_d  = w_head;
          state_d = ST_D;
        end
      end
      ST_D: begin
        if (lst_done) begin
          if (kind_q == KIND_TICK && !lst_hit) fault_d = note_fault(fault_q, FAULT_FULL);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          onext_d  = next_ext[15:0];
          ofault_d = fault_q;
          owc_d    = wc_ext[6:0];
          orc_d    = rc_ext[6:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      fault_q  <= FAULT_NONE;
      kind_q   <= KIND_ADD_WAIT;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      fault_q  <= fault_d;
      kind_q   <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    must_q   <= must_d;
    next_q   <= next_d;
    onext_q  <= onext_d;
    ofault_q <= ofault_d;
    owc_q    <= owc_d;
    orc_q    <= orc_d;
  end

  assign rsp_o.valid         = ovalid_q;
  assign rsp_o.chosen_id     = onext_q;
  assign rsp_o.fault         = ofault_q;
  assign rsp_o.waiting_count = owc_q;
  assign rsp_o.running_count = orc_q;

  // The running list head is not needed by the sequencer.
  logic unused_r_head;
  assign unused_r_head = ^r_head;

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q == FAULT_NONE || fault_q == FAULT_NOTFOUND || fault_q == FAULT_FULL)
    else $error("fault register holds an unknown code");

  a_one_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(w_rsp.done && r_rsp.done))
    else $error("both list engines finished in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while the previous one is in flight");

endmodule

FILE: bench/round_robin_thread_queue_test.sv
module round_robin_thread_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrtq_pkg::*;

  localparam int LIST_DEPTH     = 64;
  localparam int WAIT_L         = 0;
  localparam int RUN_L          = 1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESSURE_HOLD  = 300;
  localparam int PRESSURE_AT    = 200;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_REPORTS    = 40;

  // Kinds the block leaves undecoded; they must act as a plain echo.
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    logic [15:0] chosen_id;
    logic [1:0]  fault;
    logic [6:0]  waiting_count;
    logic [6:0]  running_count;
  } rsp_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] thread_id;
    logic        must_exist;
    logic        has_exp;
    rsp_word_t   exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rrtq_cmd_if cmd_if ();
  rrtq_rsp_if rsp_if ();

  round_robin_thread_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of both thread lists, index 0 is the front.
  logic [15:0] list_ids [2][LIST_DEPTH];
  int          list_len [2];

  rsp_word_t   pending_rsp_q[$];
  logic [15:0] id_pool [16];

  int  errors;
  int  n_cmds;
  int  n_ticks;
  int  n_notfound;
  int  n_full;
  int  peak_wait;
  int  peak_run;
  int  results_seen;
  bit  tx_calm;
  bit  rx_calm;
  bit  pressure_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit list_push(int which, logic [15:0] id);
    if (list_len[which] >= LIST_DEPTH) return 1'b0;
    list_ids[which][list_len[which]] = id;
    list_len[which]++;
    return 1'b1;
  endfunction

  // Removes the first matching entry and closes the gap behind it.
  function automatic bit list_drop(int which, logic [15:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < list_len[which]; i++) begin
      if (hit < 0 && list_ids[which][i] == id) hit = i;
    end
    if (hit < 0) return 1'b0;
    for (int j = hit; j + 1 < list_len[which]; j++) begin
      list_ids[which][j] = list_ids[which][j + 1];
    end
    list_len[which]--;
    return 1'b1;
  endfunction

  function automatic rsp_word_t step_queue(logic [2:0] kind, logic [15:0] id, logic must);
    rsp_word_t   r;
    logic [15:0] head;
    r.chosen_id = id;
    r.fault     = FAULT_NONE;
    case (kind)
      KIND_ADD_WAIT: if (!list_push(WAIT_L, id)) r.fault = FAULT_FULL;
      KIND_ADD_RUN:  if (!list_push(RUN_L, id)) r.fault = FAULT_FULL;
      KIND_REM_WAIT: if (!list_drop(WAIT_L, id) && must) r.fault = FAULT_NOTFOUND;
      KIND_REM_RUN:  if (!list_drop(RUN_L, id) && must) r.fault = FAULT_NOTFOUND;
      KIND_DESTROY: begin
        void'(list_drop(RUN_L, id));
        void'(list_drop(WAIT_L, id));
      end
      KIND_TICK: begin
        if (list_len[WAIT_L] > 0) begin
          // The first fault of the tick is the one reported.
          if (!list_drop(RUN_L, id)) r.fault = FAULT_NOTFOUND;
          if (!list_push(WAIT_L, id) && r.fault == FAULT_NONE) r.fault = FAULT_FULL;
          head = list_ids[WAIT_L][0];
          void'(list_drop(WAIT_L, head));
          if (!list_push(RUN_L, head) && r.fault == FAULT_NONE) r.fault = FAULT_FULL;
          r.chosen_id = head;
        end
      end
      default: ;
    endcase
    r.waiting_count = 7'(list_len[WAIT_L]);
    r.running_count = 7'(list_len[RUN_L]);
    return r;
  endfunction

  function automatic logic [15:0] list_entry(int which);
    return list_ids[which][$urandom_range(0, list_len[which] - 1)];
  endfunction

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return id_pool[$urandom_range(0, 15)];
    if (r < 80 && list_len[WAIT_L] > 0 && r[0]) return list_entry(WAIT_L);
    if (r < 80 && list_len[RUN_L] > 0) return list_entry(RUN_L);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_cmd(input logic [2:0] kind, input logic [15:0] id, input logic must,
                          input bit has_exp = 1'b0, input rsp_word_t typed = '0);
    int        gap;
    int        r;
    rsp_word_t pred;
    if (n_cmds % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.kind       <= kind;
    cmd_if.thread_id  <= id;
    cmd_if.must_exist <= must;
    do @(posedge clk_i); while (!cmd_if.ready);
    pred = step_queue(kind, id, must);
    pending_rsp_q.push_back(has_exp ? typed : pred);
    n_cmds++;
    if (kind == KIND_TICK) n_ticks++;
    if (pred.fault == FAULT_NOTFOUND) n_notfound++;
    if (pred.fault == FAULT_FULL) n_full++;
    if (list_len[WAIT_L] > peak_wait) peak_wait = list_len[WAIT_L];
    if (list_len[RUN_L] > peak_run) peak_run = list_len[RUN_L];
  endtask

  task automatic send_random();
    int          r;
    logic [2:0]  kind;
    logic [15:0] id;
    r = $urandom_range(0, 99);
    if (r < 18) kind = KIND_ADD_WAIT;
    else if (r < 30) kind = KIND_ADD_RUN;
    else if (r < 42) kind = KIND_REM_WAIT;
    else if (r < 54) kind = KIND_REM_RUN;
    else if (r < 62) kind = KIND_DESTROY;
    else if (r < 95) kind = KIND_TICK;
    else if (r < 97) kind = KIND_SPARE_A;
    else kind = KIND_SPARE_B;
    // Keep the lists at moderate depth so removals and ticks stay cheap.
    if (kind == KIND_ADD_WAIT && list_len[WAIT_L] > 24) kind = KIND_REM_WAIT;
    if (kind == KIND_ADD_RUN && list_len[RUN_L] > 24) kind = KIND_REM_RUN;
    id = pick_id();
    if (kind == KIND_TICK && list_len[RUN_L] > 0 && $urandom_range(0, 3) != 0) begin
      id = list_entry(RUN_L);
    end
    send_cmd(kind, id, 1'($urandom_range(0, 1)));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  function automatic dir_row_t mk_row(logic [2:0] kind, logic [15:0] id, logic must,
                                      logic has_exp, logic [15:0] nxt, logic [1:0] flt,
                                      logic [6:0] wc, logic [6:0] rc);
    dir_row_t row;
    row.kind              = kind;
    row.thread_id         = id;
    row.must_exist        = must;
    row.has_exp           = has_exp;
    row.exp.chosen_id     = nxt;
    row.exp.fault         = flt;
    row.exp.waiting_count = wc;
    row.exp.running_count = rc;
    return row;
  endfunction

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    rsp_word_t want;
    int        hold;
    int        r;
    hold = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t ns: result word with none expected, got %h", $time,
                     {rsp_if.chosen_id, rsp_if.fault, rsp_if.waiting_count,
                      rsp_if.running_count});
          end
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("chosen_id", want.chosen_id, rsp_if.chosen_id);
          check_field("fault", want.fault, rsp_if.fault);
          check_field("waiting_count", want.waiting_count, rsp_if.waiting_count);
          check_field("running_count", want.running_count, rsp_if.running_count);
        end
        results_seen++;
        if (results_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      end
      @(negedge clk_i);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        hold = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else if (rx_calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_if.ready <= 1'b1;
        end else if (r < 93) begin
          rsp_if.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          rsp_if.ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t ns: no word accepted for %0d cycles, %0d results outstanding", $time,
             idle, pending_rsp_q.size());
    $display("round_robin_thread_queue_test: FAIL");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows[$];
    int          which;
    logic [2:0]  kind;
    cmd_if.valid      = 1'b0;
    cmd_if.kind       = KIND_ADD_WAIT;
    cmd_if.thread_id  = '0;
    cmd_if.must_exist = 1'b0;
    errors        = 0;
    n_cmds        = 0;
    n_ticks       = 0;
    n_notfound    = 0;
    n_full        = 0;
    peak_wait     = 0;
    peak_run      = 0;
    results_seen  = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    pressure_done = 1'b0;
    list_len[WAIT_L] = 0;
    list_len[RUN_L]  = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 16; i++) id_pool[i] = 16'($urandom_range(0, 65535));

    // Empty lists, unused kinds and the first appends have obvious results.
    dir_rows.push_back(mk_row(KIND_TICK,     16'h1234, 0, 1, 16'h1234, FAULT_NONE, 0, 0));
    dir_rows.push_back(mk_row(KIND_REM_WAIT, 16'hFFFF, 1, 1, 16'hFFFF, FAULT_NOTFOUND, 0, 0));
    dir_rows.push_back(mk_row(KIND_REM_RUN,  16'h0000, 0, 1, 16'h0000, FAULT_NONE, 0, 0));
    dir_rows.push_back(mk_row(KIND_REM_RUN,  16'hABCD, 1, 1, 16'hABCD, FAULT_NOTFOUND, 0, 0));
    dir_rows.push_back(mk_row(KIND_DESTROY,  16'h5555, 1, 1, 16'h5555, FAULT_NONE, 0, 0));
    dir_rows.push_back(mk_row(KIND_SPARE_A,  16'hFFFF, 1, 1, 16'hFFFF, FAULT_NONE, 0, 0));
    dir_rows.push_back(mk_row(KIND_SPARE_B,  16'h0000, 0, 1, 16'h0000, FAULT_NONE, 0, 0));
    dir_rows.push_back(mk_row(KIND_ADD_WAIT, 16'h0000, 0, 1, 16'h0000, FAULT_NONE, 1, 0));
    dir_rows.push_back(mk_row(KIND_ADD_WAIT, 16'hFFFF, 1, 1, 16'hFFFF, FAULT_NONE, 2, 0));
    dir_rows.push_back(mk_row(KIND_ADD_RUN,  16'h8001, 0, 1, 16'h8001, FAULT_NONE, 2, 1));
    // From here on the predictor supplies the expected word.
    dir_rows.push_back(mk_row(KIND_ADD_WAIT, 16'h0000, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_TICK,     16'h8001, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_REM_WAIT, 16'h0000, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_TICK,     16'h7777, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_ADD_RUN,  16'h7FFE, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_DESTROY,  16'h0000, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_REM_RUN,  16'h1234, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_REM_WAIT, 16'hFFFF, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_TICK,     16'h7FFE, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_DESTROY,  16'h8001, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_DESTROY,  16'hFFFF, 0, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_REM_RUN,  16'h7FFE, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_REM_WAIT, 16'h7777, 1, 0, '0, '0, '0, '0));
    dir_rows.push_back(mk_row(KIND_TICK,     16'h0000, 0, 0, '0, '0, '0, '0));

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].kind, dir_rows[i].thread_id, dir_rows[i].must_exist,
               dir_rows[i].has_exp, dir_rows[i].exp);
    end

    repeat (300) send_random();

    // Fill both lists past capacity, tick while full, then empty them again.
    repeat (LIST_DEPTH + 2) send_cmd(KIND_ADD_WAIT, pick_id(), 1'($urandom_range(0, 1)));
    repeat (LIST_DEPTH + 2) send_cmd(KIND_ADD_RUN, pick_id(), 1'($urandom_range(0, 1)));
    repeat (6) send_cmd(KIND_TICK, list_entry(RUN_L), 1'($urandom_range(0, 1)));
    repeat (2) send_cmd(KIND_TICK, 16'($urandom_range(0, 65535)), 1'b0);
    while (list_len[WAIT_L] + list_len[RUN_L] > 0) begin
      which = $urandom_range(WAIT_L, RUN_L);
      if (list_len[which] == 0) which = (which == WAIT_L) ? RUN_L : WAIT_L;
      if ($urandom_range(0, 3) == 0) kind = KIND_DESTROY;
      else kind = (which == WAIT_L) ? KIND_REM_WAIT : KIND_REM_RUN;
      send_cmd(kind, list_entry(which), 1'b1);
    end

    repeat (330) send_random();

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_rsp_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands including %0d schedule ticks; %0d not-found and %0d full faults.",
             n_cmds, n_ticks, n_notfound, n_full);
    $display("Lists reached %0d waiting and %0d running entries; %0d mismatches.",
             peak_wait, peak_run, errors);
    if (errors == 0 && pending_rsp_q.size() == 0) begin
      $display("round_robin_thread_queue_test: PASS");
    end else begin
      $display("round_robin_thread_queue_test: FAIL");
    end
    $finish;
  end

endmodule
